[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file lpsl_checker.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[rtl/lpsl_pkg.sv]
// ---------------------------------------------------------------------------
// lpsl_pkg
// Types, constants and tables of the linear path steering law.
// ---------------------------------------------------------------------------
package lpsl_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_TAB = 24;
  localparam int STG_W = $clog2(NUM_TAB);
  localparam logic signed [33:0] ANG_PI = 34'sd3373259426;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_K0 = 34'sd652032874;
  localparam logic signed [16:0] HD_PI = 17'sd25736;
  localparam logic signed [16:0] HD_TWO_PI = 17'sd51472;
  localparam logic [1:0] REG_GAIN_ALONG = 2'd0;
  localparam logic [1:0] REG_GAIN_HEADING = 2'd1;
  localparam logic [1:0] REG_GAIN_LATERAL = 2'd2;
  localparam logic [1:0] REG_TURN_LIMIT = 2'd3;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [15:0] target_heading;
    logic signed [31:0] target_speed;
    logic signed [31:0] target_turn_rate;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
  } request_t;

  typedef struct packed {
    logic signed [31:0] speed_command;
    logic signed [31:0] turn_command;
    logic signed [31:0] lateral_error;
    logic signed [31:0] along_track_error;
    logic signed [15:0] heading_error;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic               flip;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] tv;
    logic signed [31:0] tw;
    logic signed [15:0] he;
  } cell_t;

  function automatic logic signed [33:0] atan_tab(input int i);
    case (i)
      0: atan_tab = 34'sh3243F6A8;
      1: atan_tab = 34'sh1DAC6705;
      2: atan_tab = 34'sh0FADBAFC;
      3: atan_tab = 34'sh07F56EA6;
      4: atan_tab = 34'sh03FEAB76;
      5: atan_tab = 34'sh01FFD55B;
      6: atan_tab = 34'sh00FFFAAA;
      7: atan_tab = 34'sh007FFF55;
      8: atan_tab = 34'sh003FFFEA;
      9: atan_tab = 34'sh001FFFFD;
      10: atan_tab = 34'sh000FFFFF;
      11: atan_tab = 34'sh0007FFFF;
      12: atan_tab = 34'sh0003FFFF;
      13: atan_tab = 34'sh0001FFFF;
      14: atan_tab = 34'sh0000FFFF;
      15: atan_tab = 34'sh00007FFF;
      16: atan_tab = 34'sh00003FFF;
      17: atan_tab = 34'sh00001FFF;
      18: atan_tab = 34'sh00000FFF;
      19: atan_tab = 34'sh000007FF;
      20: atan_tab = 34'sh000003FF;
      21: atan_tab = 34'sh000001FF;
      22: atan_tab = 34'sh000000FF;
      23: atan_tab = 34'sh0000007F;
      default: atan_tab = 34'sh0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) sat32 = 32'sh7FFFFFFF;
    else if (v < -64'sh80000000) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

[rtl/linear_path_steering_law.sv]
// ---------------------------------------------------------------------------
// linear_path_steering_law
// Path-following steering law over a chain of CORDIC cells.
// ---------------------------------------------------------------------------
// A request enters every cycle unless the output stalls; it passes through
// one input register, one cell per CORDIC rotation, then three stages
// for the projections, gain products and clamp. Output stall freezes the
// whole chain; the output register keeps the result until taken.
module linear_path_steering_law (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpsl_pkg::request_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpsl_pkg::result_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import lpsl_pkg::*;
  logic en;
  logic signed [15:0] gain_along, gain_head, gain_lat;
  logic [30:0] turn_limit;
  cell_t chain [0:CORDIC_STAGES];
  cell_t head;
  logic signed [33:0] z0;
  logic signed [16:0] hd;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_along <= '0; gain_head <= '0; gain_lat <= '0;
      turn_limit <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_ALONG: gain_along <= cfg_data[15:0];
        REG_GAIN_HEADING: gain_head <= cfg_data[15:0];
        REG_GAIN_LATERAL: gain_lat <= cfg_data[15:0];
        REG_TURN_LIMIT: turn_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    z0 = 34'(in_data.target_heading) * 34'sd131072;
    hd = 17'(in_data.target_heading) - 17'(in_data.pose_heading);
    head.valid = in_valid;
    head.flip = 1'b0;
    head.z = z0;
    if (z0 > ANG_HALF_PI) begin
      head.z = z0 - ANG_PI; head.flip = 1'b1;
    end else if (z0 < -ANG_HALF_PI) begin
      head.z = z0 + ANG_PI; head.flip = 1'b1;
    end
    head.x = CORDIC_K0;
    head.y = '0;
    head.dx = 33'(in_data.target_x) - 33'(in_data.pose_x);
    head.dy = 33'(in_data.target_y) - 33'(in_data.pose_y);
    head.tv = in_data.target_speed;
    head.tw = in_data.target_turn_rate;
    if (hd > HD_PI) hd = hd - HD_TWO_PI;
    else if (hd < -HD_PI) hd = hd + HD_TWO_PI;
    head.he = hd[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) chain[0].valid <= 1'b0;
    else if (en) chain[0].valid <= head.valid;
    if (en) begin
      chain[0].flip <= head.flip; chain[0].x <= head.x; chain[0].y <= head.y;
      chain[0].z <= head.z; chain[0].dx <= head.dx; chain[0].dy <= head.dy;
      chain[0].tv <= head.tv; chain[0].tw <= head.tw; chain[0].he <= head.he;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    lpsl_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .stage(STG_W'(g)),
      .din(chain[g]), .dout(chain[g+1])
    );
  end

  lpsl_post u_post (
    .clk(clk), .rst(rst), .en(en), .din(chain[CORDIC_STAGES]),
    .gain_along(gain_along), .gain_head(gain_head), .gain_lat(gain_lat),
    .turn_limit(turn_limit), .valid(out_valid), .res(out_data)
  );
endmodule

[rtl/lpsl_cell.sv]
// ---------------------------------------------------------------------------
// lpsl_cell
// One CORDIC rotation cell; carries the request context to its neighbor.
// ---------------------------------------------------------------------------
module lpsl_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [lpsl_pkg::STG_W-1:0]  stage,
  input  lpsl_pkg::cell_t             din,
  output lpsl_pkg::cell_t             dout
);
  import lpsl_pkg::*;
  cell_t nxt;
  logic signed [33:0] xs, ys;
  always_comb begin
    xs = din.x >>> stage;
    ys = din.y >>> stage;
    nxt = din;
    if (din.z >= 0) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - atan_tab(int'(stage));
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + atan_tab(int'(stage));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (en) dout.valid <= din.valid;
    if (en) begin
      dout.flip <= nxt.flip; dout.x <= nxt.x; dout.y <= nxt.y; dout.z <= nxt.z;
      dout.dx <= nxt.dx; dout.dy <= nxt.dy; dout.tv <= nxt.tv;
      dout.tw <= nxt.tw; dout.he <= nxt.he;
    end
  end
endmodule

[rtl/lpsl_post.sv]
// ---------------------------------------------------------------------------
// lpsl_post
// Projection, gain terms, saturation and clamp, three registered stages.
// ---------------------------------------------------------------------------
module lpsl_post (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  lpsl_pkg::cell_t      din,
  input  logic signed [15:0]   gain_along,
  input  logic signed [15:0]   gain_head,
  input  logic signed [15:0]   gain_lat,
  input  logic [30:0]          turn_limit,
  output logic                 valid,
  output lpsl_pkg::result_t    res
);
  import lpsl_pkg::*;
  logic signed [33:0] c, s;
  logic v1, v2;
  logic signed [66:0] p_lc, p_ls, p_ac, p_as;
  logic signed [31:0] tv1, tw1, tv2, tw2;
  logic signed [15:0] he1, he2;
  logic signed [31:0] lat2, along2;
  logic signed [67:0] lat_sum, along_sum;
  logic signed [47:0] m_sp, m_he, m_lat;
  logic signed [49:0] acc_sp, acc_tn;
  logic signed [41:0] turn;
  logic signed [41:0] lim;
  always_comb begin
    c = din.flip ? -din.x : din.x;
    s = din.flip ? -din.y : din.y;
    lat_sum = 68'(p_lc >>> 1) + 68'(p_ls >>> 1) + 68'sd268435456;
    along_sum = 68'(p_ac >>> 1) + 68'(p_as >>> 1) + 68'sd268435456;
    acc_sp = 50'(tv2) * 50'sd256 + 50'(m_sp) + 50'sd128;
    acc_tn = 50'(tw2) * 50'sd256 + 50'(m_he) * 50'sd8 + 50'(m_lat) + 50'sd128;
    turn = 42'(acc_tn >>> 8);
    lim = 42'($signed({1'b0, turn_limit}));
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; valid <= 1'b0;
    end else if (en) begin
      v1 <= din.valid; v2 <= v1; valid <= v2;
    end
    if (en) begin
      p_lc <= 67'(din.dx) * 67'(-s);
      p_ls <= 67'(din.dy) * 67'(c);
      p_ac <= 67'(din.dx) * 67'(c);
      p_as <= 67'(din.dy) * 67'(s);
      tv1 <= din.tv; tw1 <= din.tw; he1 <= din.he;
      lat2 <= sat32(64'(lat_sum >>> 29));
      along2 <= sat32(64'(along_sum >>> 29));
      tv2 <= tv1; tw2 <= tw1; he2 <= he1;
      m_sp <= 48'(gain_along) * 48'(sat32(64'(along_sum >>> 29)));
      m_he <= 48'(gain_head) * 48'(he1);
      m_lat <= 48'(gain_lat) * 48'(sat32(64'(lat_sum >>> 29)));
      res.lateral_error <= lat2;
      res.along_track_error <= along2;
      res.heading_error <= he2;
      res.speed_command <= sat32(64'(acc_sp >>> 8));
      if (turn > lim) res.turn_command <= lim[31:0];
      else if (turn < -lim) res.turn_command <= 32'(-lim);
      else res.turn_command <= turn[31:0];
    end
  end
endmodule

[rtl/lpsl_checker.sv]
// ---------------------------------------------------------------------------
// lpsl_checker
// Port-level checks of the steering law, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module lpsl_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input lpsl_pkg::result_t out_data
);
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_ready, clk, rst, !out_valid, in_ready)
  `ASSERT_IMPL(a_stall, clk, rst, out_valid && !out_ready, !in_ready)
  `ASSERT_IMPL(a_he, clk, rst, out_valid,
    out_data.heading_error <= 16'sd25736 && out_data.heading_error >= -16'sd25736)
endmodule

bind linear_path_steering_law lpsl_checker u_lpsl_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Testbench of linear_path_steering_law: random and directed control ticks
// under several idling phases and gain settings, checked against a
// bit-accurate predictor of the steering law.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lpsl_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  request_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  linear_path_steering_law i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [63:0] k_along, k_heading, k_lateral, turn_cap;
  request_t pending_q[$];
  result_t command_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_send = 0;
  bit have_cfg = 0;
  logic [1:0] cfg_idx_next;
  logic [31:0] cfg_val_next;

  function automatic logic signed [63:0] shr(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [63:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] cordic_angle(int i);
    logic signed [63:0] t[24];
    t = '{64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
          64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
          64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
          64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
          64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F};
    return t[i];
  endfunction

  function automatic logic signed [63:0] proj(logic signed [63:0] a, logic signed [63:0] ca,
                                              logic signed [63:0] b, logic signed [63:0] cb);
    logic signed [63:0] sum;
    sum = shr(a * ca, 1) + shr(b * cb, 1);
    return clip32(shr(sum + (64'sd1 <<< 28), 29));
  endfunction

  function automatic result_t steer(request_t r);
    result_t o;
    logic signed [63:0] z, x, y, nx, c, s, dx, dy, lat, along, he, acc, turn;
    bit flip;
    z = 64'(r.target_heading) * 131072;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z = z - 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z = z + 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        z = z - cordic_angle(i);
      end else begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        z = z + cordic_angle(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    dx = 64'(r.target_x) - 64'(r.pose_x);
    dy = 64'(r.target_y) - 64'(r.pose_y);
    lat = proj(dx, -s, dy, c);
    along = proj(dx, c, dy, s);
    he = 64'(r.target_heading) - 64'(r.pose_heading);
    while (he > 25736) he = he - 51472;
    while (he < -25736) he = he + 51472;
    acc = 64'(r.target_speed) * 256 + k_along * along;
    o.speed_command = 32'(clip32(shr(acc + 128, 8)));
    acc = 64'(r.target_turn_rate) * 256 + k_heading * he * 8 + k_lateral * lat;
    turn = shr(acc + 128, 8);
    if (turn > turn_cap) turn = turn_cap;
    if (turn < -turn_cap) turn = -turn_cap;
    o.turn_command = 32'(turn);
    o.lateral_error = 32'(lat);
    o.along_track_error = 32'(along);
    o.heading_error = 16'(he);
    return o;
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_heading();
    case ($urandom_range(0, 7))
      0: return 16'(25736);
      1: return 16'(-25736);
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 51472) - 25736);
    endcase
  endfunction

  function automatic request_t rand_tick();
    request_t r;
    r.target_x = rand32();
    r.target_y = rand32();
    r.target_heading = rand_heading();
    r.target_speed = rand32();
    r.target_turn_rate = rand32();
    if ($urandom_range(0, 3) != 0) begin
      r.pose_x = r.target_x + ($urandom_range(0, 400000) - 200000);
      r.pose_y = r.target_y + ($urandom_range(0, 400000) - 200000);
    end else begin
      r.pose_x = rand32();
      r.pose_y = rand32();
    end
    r.pose_heading = rand_heading();
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        command_q.push_back(steer(in_data));
        void'(pending_q.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_q.size() > 0 && !hold_send && !have_cfg
            && $urandom_range(0, 99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // configuration writer
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      case (cfg_index)
        REG_GAIN_ALONG: k_along = 64'(signed'(cfg_data[15:0]));
        REG_GAIN_HEADING: k_heading = 64'(signed'(cfg_data[15:0]));
        REG_GAIN_LATERAL: k_lateral = 64'(signed'(cfg_data[15:0]));
        REG_TURN_LIMIT: turn_cap = 64'(cfg_data[30:0]);
        default: ;
      endcase
      have_cfg = 0;
    end else if (have_cfg && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_next;
      cfg_data <= cfg_val_next;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (command_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          result_t e;
          e = command_q.pop_front();
          if (out_data.speed_command !== e.speed_command) begin
            $error("speed_command exp %0d got %0d", e.speed_command, out_data.speed_command);
            errors++;
          end
          if (out_data.turn_command !== e.turn_command) begin
            $error("turn_command exp %0d got %0d", e.turn_command, out_data.turn_command);
            errors++;
          end
          if (out_data.lateral_error !== e.lateral_error) begin
            $error("lateral_error exp %0d got %0d", e.lateral_error, out_data.lateral_error);
            errors++;
          end
          if (out_data.along_track_error !== e.along_track_error) begin
            $error("along_track_error exp %0d got %0d", e.along_track_error,
                   out_data.along_track_error);
            errors++;
          end
          if (out_data.heading_error !== e.heading_error) begin
            $error("heading_error exp %0d got %0d", e.heading_error, out_data.heading_error);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || command_q.size() != 0) @(posedge clk);
    repeat (CORDIC_STAGES + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_idx_next = idx;
    cfg_val_next = val;
    have_cfg = 1;
    while (have_cfg) @(posedge clk);
  endtask

  task automatic set_gains(logic [31:0] a, logic [31:0] h, logic [31:0] l, logic [31:0] m);
    drain();
    write_reg(REG_GAIN_ALONG, a);
    write_reg(REG_GAIN_HEADING, h);
    write_reg(REG_GAIN_LATERAL, l);
    write_reg(REG_TURN_LIMIT, m);
  endtask

  task automatic push_tick(int x, int y, int th, int v, int w, int px, int py, int ph);
    request_t r;
    r.target_x = x;
    r.target_y = y;
    r.target_heading = 16'(th);
    r.target_speed = v;
    r.target_turn_rate = w;
    r.pose_x = px;
    r.pose_y = py;
    r.pose_heading = 16'(ph);
    pending_q.push_back(r);
  endtask

  initial begin
    k_along = 0;
    k_heading = 0;
    k_lateral = 0;
    turn_cap = 65536;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset settings first
    push_tick(65536, 0, 0, 65536, 0, 0, 0, 0);
    push_tick(0, 0, 25736, 0, 200000, 0, 0, -25736);
    drain();
    set_gains(32'h0000_0100, 32'h0000_0200, 32'h0000_0080, 32'h7FFF_FFFF);
    push_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000, 32'sh80000000, 0);
    push_tick(32'sh80000000, 32'sh80000000, 12868, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, -12868);
    push_tick(100, 200, -25736, 32'sh80000000, 32'sh80000000, 0, 0, 25736);
    push_tick(0, 65536, 32767, 0, 0, 0, 0, -32768);
    push_tick(0, 65536, -32768, 0, 0, 0, 0, 32767);
    push_tick(65536, 65536, 13000, 0, 0, 0, 0, 0);
    push_tick(65536, 65536, -13000, 0, 0, 0, 0, 0);
    push_tick(1, 1, 0, -1, -1, 0, 0, 0);
    push_tick(32768, 0, 0, 0, 0, 0, 0, 0);
    set_gains(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0);
    push_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 20000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh80000000, 0, -20000);
    push_tick(32'sh80000000, 5, -20000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 0, 20000);
    set_gains(32'hFFFF_7FFF, 32'h0000_7FFF, 32'hFFFF_7FFF, 32'h0000_0001);
    push_tick(32'sh7FFFFFFF, 32'sh80000000, 25736, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, -25736);
    push_tick(-65536, 0, 6434, 0, 1000, 0, 65536, 0);
    drain();
    write_reg(REG_TURN_LIMIT, 32'hFFFF_FFFF);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 65; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 65; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      if (ph == 4) set_gains(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      else if (ph > 0)
        set_gains($urandom, $urandom, $urandom,
                  ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 24));
      for (int n = 0; n < 190; n++) begin
        pending_q.push_back(rand_tick());
        if (n == 95 && ph == 2) begin
          while (pending_q.size() != 0 || in_valid) @(posedge clk);
          hold_send = 1;
          while (command_q.size() != 0) @(posedge clk);
          hold_send = 0;
        end
      end
      while (pending_q.size() > 20) @(posedge clk);
    end
    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/lpsl_pkg.sv
rtl/lpsl_cell.sv
rtl/lpsl_post.sv
rtl/linear_path_steering_law.sv
rtl/lpsl_checker.sv
tb/tb.sv
